FILE: src/ffc_pkg.sv
// Shared command codes and format constants for the float format converter.
`default_nettype none

package ffc_pkg;

  typedef enum logic [1:0] {
    CMD_HALF_TO_SINGLE = 2'd0,
    CMD_BF16_TO_SINGLE = 2'd1,
    CMD_SINGLE_TO_HALF = 2'd2,
    CMD_SINGLE_TO_BF16 = 2'd3
  } cmd_e;

  localparam logic [7:0]  SingleExpMax    = 8'hff;
  localparam logic [7:0]  HalfToSingleAdj = 8'd112;
  localparam logic [7:0]  HalfSubnormBase = 8'd113;
  localparam logic [4:0]  HalfExpMax      = 5'h1f;
  localparam logic [15:0] HalfInf         = 16'h7c00;
  localparam logic [23:0] HalfRoundBit    = 24'h001000;
  localparam logic [31:0] Bf16RoundBias   = 32'h00007fff;

endpackage : ffc_pkg

`default_nettype wire

FILE: src/float_format_converter_core.sv
// Top level of the float format converter: input register, conversion logic, result register.
`default_nettype none

// Converts one raw floating-point bit pattern per item between half, bfloat16 and
// single precision, as picked by command_i. An item is taken at every clock edge
// where start is high; busy stays low, so a new item can enter every cycle. Each
// result appears on result_bits_o with done_o high for exactly one cycle: the item
// is captured in the input register, the conversion logic works on it, and the
// result register then loads the result. The receiver takes the result while
// done_o is high. Results leave in the order the items came in and cannot be held
// off by the receiver.
// 16-bit results sit in the low half of result_bits_o with the upper half zero.
module float_format_converter_core
  import ffc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] source_bits_i,
  output logic             done_o,
  output logic      [31:0] result_bits_o
);

  logic        in_valid_q;
  logic [1:0]  cmd_q;
  logic [31:0] src_q;
  logic        out_valid_q;
  logic [31:0] result_q;
  logic [31:0] result_d;

  logic [31:0] h2s_bits;
  logic [15:0] s2h_bits;
  logic [31:0] bf16_sum;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start && !busy;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= command_i;
      src_q <= source_bits_i;
    end
    if (in_valid_q) begin
      result_q <= result_d;
    end
  end

  ffc_half_to_single u_h2s (
    .half_i   (src_q[15:0]),
    .single_o (h2s_bits)
  );

  ffc_single_to_half u_s2h (
    .single_i (src_q),
    .half_o   (s2h_bits)
  );

  // Round to nearest even by adding a bias; the 32-bit add wraps.
  assign bf16_sum = src_q + Bf16RoundBias + {31'd0, src_q[16]};

  always_comb begin
    case (cmd_e'(cmd_q))
      CMD_HALF_TO_SINGLE: result_d = h2s_bits;
      CMD_BF16_TO_SINGLE: result_d = {src_q[15:0], 16'd0};
      CMD_SINGLE_TO_HALF: result_d = {16'd0, s2h_bits};
      CMD_SINGLE_TO_BF16: result_d = {16'd0, bf16_sum[31:16]};
      default:            result_d = 32'd0;
    endcase
  end

  assign done_o        = out_valid_q;
  assign result_bits_o = result_q;

  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("accepted item produced no result two cycles later");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_valid_q))
    else $error("result strobe without a staged item");

  a_narrow_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (cmd_q == CMD_SINGLE_TO_HALF || cmd_q == CMD_SINGLE_TO_BF16))
    |=> result_bits_o[31:16] == 16'd0)
    else $error("16-bit result has a nonzero upper half");

  a_bf16_widen_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && cmd_q == CMD_BF16_TO_SINGLE)
    |=> result_bits_o == {$past(src_q[15:0]), 16'd0})
    else $error("bfloat16 widening result mismatch");

endmodule : float_format_converter_core

`default_nettype wire

FILE: src/ffc_half_to_single.sv
// Widening conversion from IEEE half precision to IEEE single precision.
`default_nettype none

module ffc_half_to_single
  import ffc_pkg::*;
(
  input  wire logic [15:0] half_i,
  output logic      [31:0] single_o
);

  logic        sign;
  logic [4:0]  expo;
  logic [9:0]  mant;
  logic [3:0]  shifts;
  logic [10:0] norm;
  logic [7:0]  sub_exp;

  assign sign = half_i[15];
  assign expo = half_i[14:10];
  assign mant = half_i[9:0];

  // Leading-zero count of a subnormal mantissa: the shift that brings the
  // top set bit up to the hidden-bit position.
  always_comb begin
    shifts = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (mant[i]) begin
        shifts = 4'(10 - i);
      end
    end
  end

  assign norm    = {1'b0, mant} << shifts;
  assign sub_exp = HalfSubnormBase - {4'd0, shifts};

  always_comb begin
    if (expo == 5'd0) begin
      if (mant == 10'd0) begin
        single_o = {sign, 31'd0};
      end else begin
        single_o = {sign, sub_exp, norm[9:0], 13'd0};
      end
    end else if (expo == HalfExpMax) begin
      single_o = {sign, SingleExpMax, mant, 13'd0};
    end else begin
      single_o = {sign, {3'd0, expo} + HalfToSingleAdj, mant, 13'd0};
    end
  end

endmodule : ffc_half_to_single

`default_nettype wire

FILE: src/ffc_single_to_half.sv
// Narrowing conversion from IEEE single to half precision, rounding ties away from zero.
`default_nettype none

module ffc_single_to_half
  import ffc_pkg::*;
(
  input  wire logic [31:0] single_i,
  output logic      [15:0] half_o
);

  logic        sign;
  logic [7:0]  efield;
  logic [22:0] mant;
  logic [3:0]  sub_shift;
  logic [23:0] sub_shifted;
  logic [24:0] sub_rounded;
  logic [23:0] norm_rounded;
  logic [4:0]  norm_exp;
  logic [5:0]  norm_exp_inc;

  assign sign   = single_i[31];
  assign efield = single_i[30:23];
  assign mant   = single_i[22:0];

  // Subnormal half range: efield 102..112 gives a right shift of 1..11.
  assign sub_shift    = 4'(HalfSubnormBase - efield);
  assign sub_shifted  = {1'b1, mant} >> sub_shift;
  assign sub_rounded  = {1'b0, sub_shifted} + {1'b0, HalfRoundBit};

  // Normal half range: efield 113..142, so the biased exponent is 1..30.
  assign norm_exp     = 5'(efield - HalfToSingleAdj);
  assign norm_rounded = {1'b0, mant} + HalfRoundBit;
  assign norm_exp_inc = {1'b0, norm_exp} + 6'd1;

  always_comb begin
    if (efield == SingleExpMax) begin
      if (mant == 23'd0) begin
        half_o = {sign, 15'd0} | HalfInf;
      end else begin
        half_o = {sign, 15'd0} | HalfInf | {6'd0, mant[22:13]} | 16'd1;
      end
    end else if (efield <= HalfToSingleAdj) begin
      if (efield < 8'd102) begin
        half_o = {sign, 15'd0};
      end else begin
        half_o = {sign, 4'd0, sub_rounded[23:13]};
      end
    end else if (efield >= 8'd143) begin
      half_o = {sign, 15'd0} | HalfInf;
    end else if (norm_rounded[23]) begin
      // Rounding carried out of the mantissa into the exponent.
      if (norm_exp_inc >= {1'b0, HalfExpMax}) begin
        half_o = {sign, 15'd0} | HalfInf;
      end else begin
        half_o = {sign, norm_exp_inc[4:0], 10'd0};
      end
    end else begin
      half_o = {sign, norm_exp, norm_rounded[22:13]};
    end
  end

endmodule : ffc_single_to_half

`default_nettype wire

FILE: test/ffc_checker.sv
// Scoreboard for the float format converter: predicts each converted pattern and compares it.
`timescale 1ns / 1ps

module ffc_checker
  import ffc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] source_bits_i,
  input  wire logic        done_o,
  input  wire logic [31:0] result_bits_o,
  output int unsigned      fail_count_o,
  output int unsigned      pending_count_o
);

  logic [31:0] awaited_patterns[$];

  function automatic logic [31:0] convert_pattern(cmd_e cmd, logic [31:0] src);
    logic [31:0] sign_bits;
    logic [31:0] mant;
    logic [31:0] shifted;
    logic [31:0] bias;
    logic [31:0] sum;
    logic [31:0] res;
    logic [4:0]  half_exp;
    int          expo;
    int unsigned shifts;
    res = '0;
    case (cmd)
      CMD_HALF_TO_SINGLE: begin
        sign_bits = {src[15], 31'b0};
        half_exp  = src[14:10];
        mant      = {22'b0, src[9:0]};
        if (half_exp == 5'd0) begin
          if (mant == 32'd0) begin
            res = sign_bits;
          end else begin
            // Subnormal half: shift until the hidden bit position is reached.
            shifts = 0;
            while (mant[10] == 1'b0 && shifts < 11) begin
              mant = mant << 1;
              shifts++;
            end
            res = sign_bits | ((32'd113 - 32'(shifts)) << 23) | ({22'b0, mant[9:0]} << 13);
          end
        end else if (half_exp == 5'h1f) begin
          res = sign_bits | 32'h7f80_0000 | (mant << 13);
        end else begin
          res = sign_bits | ((32'(half_exp) + 32'd112) << 23) | (mant << 13);
        end
      end
      CMD_BF16_TO_SINGLE: begin
        res = {src[15:0], 16'b0};
      end
      CMD_SINGLE_TO_HALF: begin
        sign_bits = {16'b0, src[31], 15'b0};
        mant      = {9'b0, src[22:0]};
        expo      = int'(src[30:23]) - 112;
        if (src[30:23] == 8'hff) begin
          res = (mant == 32'd0) ? (sign_bits | 32'h7c00)
                                : (sign_bits | 32'h7c00 | (mant >> 13) | 32'd1);
        end else if (expo <= 0) begin
          if (expo < -10) begin
            res = sign_bits;
          end else begin
            mant    = mant | 32'h0080_0000;
            shifted = mant >> (1 - expo);
            res     = sign_bits | ((shifted + 32'h1000) >> 13);
          end
        end else if (expo >= 31) begin
          res = sign_bits | 32'h7c00;
        end else begin
          mant = mant + 32'h1000;
          // A rounding carry out of the mantissa bumps the exponent.
          if (mant[23]) begin
            mant = '0;
            expo++;
          end
          if (expo >= 31) begin
            res = sign_bits | 32'h7c00;
          end else begin
            res = sign_bits | (32'(expo) << 10) | ((mant >> 13) & 32'h3ff);
          end
        end
        res = res & 32'hffff;
      end
      default: begin
        bias = 32'h7fff + {31'b0, src[16]};
        sum  = src + bias;
        res  = {16'b0, sum[31:16]};
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && done_o) begin
      if (awaited_patterns.size() == 0) begin
        $display("%0t: unexpected result %08h", $time, result_bits_o);
        fail_count_o++;
      end else begin
        want = awaited_patterns.pop_front();
        if (result_bits_o !== want) begin
          $display("%0t: result_bits mismatch: expected %08h, actual %08h",
                   $time, want, result_bits_o);
          fail_count_o++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      awaited_patterns.push_back(convert_pattern(cmd_e'(command_i), source_bits_i));
    end
    pending_count_o = awaited_patterns.size();
  end

endmodule : ffc_checker

FILE: test/testbench.sv
// Top of the float format converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import ffc_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        start         = 1'b0;
  logic [1:0]  command_i     = CMD_HALF_TO_SINGLE;
  logic [31:0] source_bits_i = '0;
  logic        busy;
  logic        done_o;
  logic [31:0] result_bits_o;
  int unsigned fail_count;
  int unsigned pending_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  float_format_converter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .source_bits_i (source_bits_i),
    .done_o        (done_o),
    .result_bits_o (result_bits_o)
  );

  ffc_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .source_bits_i   (source_bits_i),
    .done_o          (done_o),
    .result_bits_o   (result_bits_o),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic send_item(cmd_e cmd, logic [31:0] src, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    command_i     <= cmd;
    source_bits_i <= src;
    // Busy only moves on rising edges, so its value at the falling edge holds at the next one.
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Random source pattern, steered toward exponent ranges where the conversions branch.
  function automatic logic [31:0] random_source(cmd_e cmd);
    logic [31:0] src;
    int unsigned pick;
    src  = $urandom;
    pick = $urandom_range(0, 7);
    case (cmd)
      CMD_HALF_TO_SINGLE: begin
        if (pick < 2) src[14:10] = 5'd0;
        else if (pick == 2) src[14:10] = 5'h1f;
      end
      CMD_SINGLE_TO_HALF: begin
        if (pick < 5) begin
          src[30:23] = 8'($urandom_range(98, 146));
        end else if (pick == 5) begin
          src[30:23] = 8'hff;
        end else if (pick == 6) begin
          src[30:23] = 8'($urandom_range(100, 142));
          src[12:0]  = 13'h1000;
        end
      end
      CMD_SINGLE_TO_BF16: begin
        if (pick < 2) src[15:0] = 16'h8000;
        else if (pick == 2) src[30:23] = 8'hff;
      end
      default: begin
      end
    endcase
    return src;
  endfunction

  initial begin
    cmd_e        cmd;
    int unsigned gap;
    int unsigned guard;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Half to single: zeros, subnormals, smallest normal, infinities, NaN, upper half ignored.
    send_item(CMD_HALF_TO_SINGLE, 32'h0000_0000, 0);
    send_item(CMD_HALF_TO_SINGLE, 32'h0000_8000, 0);
    send_item(CMD_HALF_TO_SINGLE, 32'h0000_0001, 1);
    send_item(CMD_HALF_TO_SINGLE, 32'h0000_83ff, 0);
    send_item(CMD_HALF_TO_SINGLE, 32'h0000_0400, 0);
    send_item(CMD_HALF_TO_SINGLE, 32'h0000_7c00, 2);
    send_item(CMD_HALF_TO_SINGLE, 32'h0000_fc00, 0);
    send_item(CMD_HALF_TO_SINGLE, 32'hffff_7e01, 0);
    // Bfloat16 to single.
    send_item(CMD_BF16_TO_SINGLE, 32'hffff_ffff, 0);
    send_item(CMD_BF16_TO_SINGLE, 32'h1234_0000, 3);
    // Single to half: infinities, NaN with a payload that truncates away, zero and subnormal,
    // the edge of the subnormal range, a carry into the smallest normal, and overflow.
    send_item(CMD_SINGLE_TO_HALF, 32'h7f80_0000, 0);
    send_item(CMD_SINGLE_TO_HALF, 32'hff80_0000, 0);
    send_item(CMD_SINGLE_TO_HALF, 32'h7f80_0001, 0);
    send_item(CMD_SINGLE_TO_HALF, 32'hffc0_0000, 1);
    send_item(CMD_SINGLE_TO_HALF, 32'h0000_0000, 0);
    send_item(CMD_SINGLE_TO_HALF, 32'h8000_0001, 0);
    send_item(CMD_SINGLE_TO_HALF, 32'h3300_0000, 0);
    send_item(CMD_SINGLE_TO_HALF, 32'h32ff_ffff, 0);
    send_item(CMD_SINGLE_TO_HALF, 32'h387f_ffff, 4);
    send_item(CMD_SINGLE_TO_HALF, 32'h477f_efff, 0);
    send_item(CMD_SINGLE_TO_HALF, 32'hc77f_f000, 0);
    send_item(CMD_SINGLE_TO_HALF, 32'h4780_0000, 0);
    // Single to bfloat16: ties both ways, a NaN that wraps to zero, a NaN that rounds over.
    send_item(CMD_SINGLE_TO_BF16, 32'h3f80_8000, 0);
    send_item(CMD_SINGLE_TO_BF16, 32'h3f81_8000, 0);
    send_item(CMD_SINGLE_TO_BF16, 32'hffff_ffff, 7);
    send_item(CMD_SINGLE_TO_BF16, 32'h7fff_ffff, 0);

    for (int n = 0; n < 1800; n++) begin
      if (n == 900) begin
        start <= 1'b0;
        do @(posedge clk_i); while (pending_count != 0);
      end
      cmd = cmd_e'($urandom_range(0, 3));
      gap = (((n / 150) % 3) == 1) ? 0 : $urandom_range(0, 7);
      send_item(cmd, random_source(cmd), gap);
    end
    start <= 1'b0;

    guard = 0;
    while (pending_count != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule : testbench
